// ===== sv/sah_pkg.sv =====
package sah_pkg;

	// Default sizes of the stores.
	localparam int DEF_MODULE_ENTRIES  = 512;
	localparam int DEF_PAGE_ENTRIES    = 4096;
	localparam int DEF_FULL_BUCKETS    = 4096;
	localparam int DEF_FULL_SHIFT_BITS = 10;
	localparam int DEF_FINE_SHIFT_BITS = 4;
	localparam int DEF_FINE_BUCKETS    = 768;

	// Page number is the module offset divided by 4 KB.
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = 32 - PAGE_SHIFT;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_COUNT  = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic [2:0] SEL_MODULE = 3'd0;
	localparam logic [2:0] SEL_PAGE   = 3'd1;
	localparam logic [2:0] SEL_FULL   = 3'd2;
	localparam logic [2:0] SEL_FINE   = 3'd3;
	localparam logic [2:0] SEL_TOTAL  = 3'd4;

	localparam logic [1:0] PS_BUMP = 2'd0;
	localparam logic [1:0] PS_NEW  = 2'd1;
	localparam logic [1:0] PS_DROP = 2'd2;

	localparam logic [1:0] CFG_FULL_MAP  = 2'd0;
	localparam logic [1:0] CFG_FINE_MOD  = 2'd1;
	localparam logic [1:0] CFG_FINE_BASE = 2'd2;

	localparam logic [9:0]  MREG_RESET      = 10'd512;
	localparam logic [31:0] FINE_BASE_RESET = 32'h0007_6000;

	localparam int TOT_ALL     = 0;
	localparam int TOT_UNKNOWN = 1;
	localparam int TOT_FULL    = 2;
	localparam int TOT_FINE    = 3;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_COUNT,
		OP_SAMPLE,
		OP_READ,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [11:0] slot;
		logic [31:0] address;
		logic [31:0] span;
		logic [2:0]  table_select;
	} req_t;

	typedef struct packed {
		logic        module_hit;
		logic [8:0]  module_index;
		logic [31:0] offset;
		logic [1:0]  page_status;
		logic [63:0] count_value;
		logic [8:0]  entry_module;
		logic [19:0] entry_page;
		logic        status;
	} res_t;

	typedef struct packed {
		logic [9:0]  full_map_module;
		logic [9:0]  fine_window_module;
		logic [31:0] fine_window_base;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_MOD_WR,
		ST_FULL_WR,
		ST_FINE_WR,
		ST_PAGE_RD,
		ST_PAGE_CMP,
		ST_HIT_WR,
		ST_INSERT,
		ST_READ_CAP,
		ST_EMIT
	} eng_state_t;

endpackage

// ===== sv/sah_fifo.sv =====
module sah_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// ===== sv/sah_front.sv =====
module sah_front import sah_pkg::*; #(
	parameter int MODULE_ENTRIES = DEF_MODULE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [11:0] slot,
	input  logic [31:0] address,
	input  logic [31:0] span,
	input  logic [2:0]  table_select,
	output logic        rq_valid,
	output req_t        rq,
	input  logic        rq_pop
);

	req_t  cls;
	logic  rq_empty;
	logic [31:0] slot32;

	// Range checks on loads and counts need no state, so they are settled here.
	always_comb begin
		slot32           = 32'(slot);
		cls.slot         = slot;
		cls.address      = address;
		cls.span         = span;
		cls.table_select = table_select;
		unique case (req_type)
			REQ_LOAD:   cls.op = (slot32 < 32'(MODULE_ENTRIES)) ? OP_LOAD : OP_REJECT;
			REQ_COUNT:  cls.op = (slot32 <= 32'(MODULE_ENTRIES)) ? OP_COUNT : OP_REJECT;
			REQ_SAMPLE: cls.op = OP_SAMPLE;
			default:    cls.op = OP_READ;
		endcase
	end

	sah_fifo #(.W($bits(req_t)), .DEPTH(2)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (rq_pop),
		.rdata (rq),
		.empty (rq_empty)
	);

	assign rq_valid = !rq_empty;

endmodule

// ===== sv/sah_engine.sv =====
module sah_engine import sah_pkg::*; #(
	parameter int MODULE_ENTRIES  = DEF_MODULE_ENTRIES,
	parameter int PAGE_ENTRIES    = DEF_PAGE_ENTRIES,
	parameter int FULL_BUCKETS    = DEF_FULL_BUCKETS,
	parameter int FULL_SHIFT_BITS = DEF_FULL_SHIFT_BITS,
	parameter int FINE_SHIFT_BITS = DEF_FINE_SHIFT_BITS,
	parameter int FINE_BUCKETS    = DEF_FINE_BUCKETS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic rq_valid,
	input  req_t rq,
	output logic rq_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	localparam int MIW = (MODULE_ENTRIES > 1) ? $clog2(MODULE_ENTRIES) : 1;
	localparam int MCW = $clog2(MODULE_ENTRIES + 1);
	localparam int PIW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
	localparam int PCW = $clog2(PAGE_ENTRIES + 1);
	localparam int FIW = (FULL_BUCKETS > 1) ? $clog2(FULL_BUCKETS) : 1;
	localparam int WIW = (FINE_BUCKETS > 1) ? $clog2(FINE_BUCKETS) : 1;
	localparam int TW  = MIW + PAGE_W;
	localparam int CLR_A   = (MODULE_ENTRIES > FULL_BUCKETS) ? MODULE_ENTRIES : FULL_BUCKETS;
	localparam int CLR_LEN = (CLR_A > FINE_BUCKETS) ? CLR_A : FINE_BUCKETS;
	localparam int CCW = $clog2(CLR_LEN + 1);

	eng_state_t state_q, state_d;

	req_t            item_q;
	res_t            res_q;
	res_t            disp_res;
	logic [MCW-1:0]  mcount_q, m_q;
	logic [PCW-1:0]  pcnt_q, i_q;
	logic [31:0]     off_q;
	logic [CCW-1:0]  clr_q;
	logic [63:0]     tot_q [4];

	// Module table, base in the upper half and size in the lower half.
	logic [63:0]    bs_mem [MODULE_ENTRIES];
	logic [63:0]    bs_rd;
	logic           bs_we;
	logic [63:0]    mh_mem [MODULE_ENTRIES];
	logic [63:0]    mh_rd, mh_wd;
	logic           mh_we;
	logic [MIW-1:0] mh_wa, mh_ra;
	logic [63:0]    full_mem [FULL_BUCKETS];
	logic [63:0]    full_rd, full_wd;
	logic           full_we;
	logic [FIW-1:0] full_wa, full_ra;
	logic [63:0]    fine_mem [FINE_BUCKETS];
	logic [63:0]    fine_rd, fine_wd;
	logic           fine_we;
	logic [WIW-1:0] fine_wa, fine_ra;
	logic [TW-1:0]  tag_mem [PAGE_ENTRIES];
	logic [TW-1:0]  tag_rd, tag_wd;
	logic           tag_we;
	logic [63:0]    hit_mem [PAGE_ENTRIES];
	logic [63:0]    hit_rd, hit_wd;
	logic           hit_we;
	logic [PIW-1:0] pg_wa, pg_ra;

	logic           is_read, clearing;
	logic [31:0]    slot32, scan_off, full_b, fine_d, fine_b;
	logic           scan_hit, full_hit, fine_hit, tag_hit, scan_last, page_last, rd_ok;
	eng_state_t     page_first;

	assign is_read  = (item_q.op == OP_READ);
	assign clearing = (state_q == ST_CLEAR);
	assign slot32   = 32'(item_q.slot);
	assign scan_off = item_q.address - bs_rd[63:32];
	assign scan_hit = scan_off < bs_rd[31:0];
	assign scan_last = (m_q + 1'b1) == mcount_q;
	assign full_b   = off_q >> FULL_SHIFT_BITS;
	assign fine_d   = off_q - cfg.fine_window_base;
	assign fine_b   = fine_d >> FINE_SHIFT_BITS;
	assign full_hit = (32'(m_q) == 32'(cfg.full_map_module)) && (full_b < 32'(FULL_BUCKETS));
	assign fine_hit = (32'(m_q) == 32'(cfg.fine_window_module)) && (fine_b < 32'(FINE_BUCKETS));
	assign tag_hit  = tag_rd == {MIW'(m_q), off_q[31:PAGE_SHIFT]};
	assign page_last  = (i_q + 1'b1) == pcnt_q;
	assign page_first = (pcnt_q == '0) ? ST_INSERT : ST_PAGE_CMP;

	// Read ports: a read request addresses by slot, a sample by its own indexes.
	assign mh_ra   = is_read ? MIW'(item_q.slot) : MIW'(m_q);
	assign full_ra = is_read ? FIW'(item_q.slot) : FIW'(full_b);
	assign fine_ra = is_read ? WIW'(item_q.slot) : WIW'(fine_b);
	assign pg_ra   = is_read ? PIW'(item_q.slot) : PIW'(i_q);

	always_comb begin
		case (item_q.table_select)
			SEL_MODULE: rd_ok = slot32 < 32'(MODULE_ENTRIES);
			SEL_PAGE:   rd_ok = slot32 < 32'(pcnt_q);
			SEL_FULL:   rd_ok = slot32 < 32'(FULL_BUCKETS);
			SEL_FINE:   rd_ok = slot32 < 32'(FINE_BUCKETS);
			SEL_TOTAL:  rd_ok = slot32 < 32'd4;
			default:    rd_ok = 1'b0;
		endcase
	end

	// Result word as it stands once the request has been decoded.
	always_comb begin
		disp_res        = '0;
		disp_res.status = (item_q.op == OP_REJECT) || (is_read && !rd_ok);
		if (is_read && rd_ok && item_q.table_select == SEL_TOTAL) begin
			disp_res.count_value = tot_q[item_q.slot[1:0]];
		end
	end

	always_comb begin
		state_d  = state_q;
		rq_pop   = 1'b0;
		res_push = 1'b0;
		bs_we    = 1'b0;
		mh_we    = 1'b0;
		mh_wa    = MIW'(m_q);
		mh_wd    = mh_rd + 64'd1;
		full_we  = 1'b0;
		full_wa  = FIW'(full_b);
		full_wd  = full_rd + 64'd1;
		fine_we  = 1'b0;
		fine_wa  = WIW'(fine_b);
		fine_wd  = fine_rd + 64'd1;
		tag_we   = 1'b0;
		tag_wd   = {MIW'(m_q), off_q[31:PAGE_SHIFT]};
		hit_we   = 1'b0;
		hit_wd   = hit_rd + 64'd1;
		pg_wa    = PIW'(i_q);
		unique case (state_q)
			ST_CLEAR: begin
				mh_we   = 32'(clr_q) < 32'(MODULE_ENTRIES);
				mh_wa   = MIW'(clr_q);
				mh_wd   = '0;
				full_we = 32'(clr_q) < 32'(FULL_BUCKETS);
				full_wa = FIW'(clr_q);
				full_wd = '0;
				fine_we = 32'(clr_q) < 32'(FINE_BUCKETS);
				fine_wa = WIW'(clr_q);
				fine_wd = '0;
				if (clr_q == CCW'(CLR_LEN - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (rq_valid) begin
					rq_pop  = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (item_q.op)
					OP_LOAD: begin
						bs_we   = 1'b1;
						state_d = ST_EMIT;
					end
					OP_SAMPLE: state_d = (mcount_q == '0) ? ST_EMIT : ST_SCAN_RD;
					OP_READ: begin
						state_d = (rd_ok && item_q.table_select != SEL_TOTAL) ?
							ST_READ_CAP : ST_EMIT;
					end
					default: state_d = ST_EMIT;
				endcase
			end
			ST_SCAN_RD: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (scan_hit) begin
					state_d = ST_MOD_WR;
				end else if (scan_last) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_MOD_WR: begin
				mh_we   = 1'b1;
				state_d = full_hit ? ST_FULL_WR : (fine_hit ? ST_FINE_WR : page_first);
			end
			ST_FULL_WR: begin
				full_we = 1'b1;
				state_d = fine_hit ? ST_FINE_WR : page_first;
			end
			ST_FINE_WR: begin
				fine_we = 1'b1;
				state_d = page_first;
			end
			ST_PAGE_RD: state_d = ST_PAGE_CMP;
			ST_PAGE_CMP: begin
				if (tag_hit) begin
					state_d = ST_HIT_WR;
				end else if (page_last) begin
					state_d = ST_INSERT;
				end else begin
					state_d = ST_PAGE_RD;
				end
			end
			ST_HIT_WR: begin
				hit_we  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_INSERT: begin
				pg_wa  = PIW'(pcnt_q);
				hit_wd = 64'd1;
				if (32'(pcnt_q) < 32'(PAGE_ENTRIES)) begin
					tag_we = 1'b1;
					hit_we = 1'b1;
				end
				state_d = ST_EMIT;
			end
			ST_READ_CAP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			mcount_q <= '0;
			pcnt_q   <= '0;
			for (int k = 0; k < 4; k++) begin
				tot_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_DISPATCH && item_q.op == OP_COUNT) begin
				mcount_q <= MCW'(item_q.slot);
			end
			if (state_q == ST_DISPATCH && item_q.op == OP_SAMPLE) begin
				tot_q[TOT_ALL] <= tot_q[TOT_ALL] + 64'd1;
				if (mcount_q == '0) begin
					tot_q[TOT_UNKNOWN] <= tot_q[TOT_UNKNOWN] + 64'd1;
				end
			end
			if (state_q == ST_SCAN_CMP && !scan_hit && scan_last) begin
				tot_q[TOT_UNKNOWN] <= tot_q[TOT_UNKNOWN] + 64'd1;
			end
			if (state_q == ST_FULL_WR) begin
				tot_q[TOT_FULL] <= tot_q[TOT_FULL] + 64'd1;
			end
			if (state_q == ST_FINE_WR) begin
				tot_q[TOT_FINE] <= tot_q[TOT_FINE] + 64'd1;
			end
			if (tag_we) begin
				pcnt_q <= pcnt_q + 1'b1;
			end
		end
	end

	// Item, indexes and the result under construction.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (rq_valid) begin
					item_q <= rq;
				end
			end
			ST_DISPATCH: begin
				res_q <= disp_res;
				m_q   <= '0;
			end
			ST_SCAN_CMP: begin
				if (scan_hit) begin
					off_q              <= scan_off;
					i_q                <= '0;
					res_q.module_hit   <= 1'b1;
					res_q.module_index <= 9'(m_q);
					res_q.offset       <= scan_off;
				end else begin
					m_q <= m_q + 1'b1;
				end
			end
			ST_PAGE_CMP: begin
				if (!tag_hit) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_HIT_WR: res_q.page_status <= PS_BUMP;
			ST_INSERT: begin
				res_q.page_status <= (32'(pcnt_q) < 32'(PAGE_ENTRIES)) ? PS_NEW : PS_DROP;
			end
			ST_READ_CAP: begin
				case (item_q.table_select)
					SEL_MODULE: res_q.count_value <= mh_rd;
					SEL_PAGE: begin
						res_q.count_value  <= hit_rd;
						res_q.entry_module <= 9'(tag_rd[TW-1:PAGE_W]);
						res_q.entry_page   <= tag_rd[PAGE_W-1:0];
					end
					SEL_FULL:   res_q.count_value <= full_rd;
					default:    res_q.count_value <= fine_rd;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bs_we) begin
			bs_mem[MIW'(item_q.slot)] <= {item_q.address, item_q.span};
		end
		bs_rd <= bs_mem[MIW'(m_q)];
	end

	always_ff @(posedge clk) begin
		if (mh_we) begin
			mh_mem[mh_wa] <= mh_wd;
		end
		mh_rd <= mh_mem[mh_ra];
	end

	always_ff @(posedge clk) begin
		if (full_we) begin
			full_mem[full_wa] <= full_wd;
		end
		full_rd <= full_mem[full_ra];
	end

	always_ff @(posedge clk) begin
		if (fine_we) begin
			fine_mem[fine_wa] <= fine_wd;
		end
		fine_rd <= fine_mem[fine_ra];
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[pg_wa] <= tag_wd;
		end
		tag_rd <= tag_mem[pg_ra];
	end

	always_ff @(posedge clk) begin
		if (hit_we) begin
			hit_mem[pg_wa] <= hit_wd;
		end
		hit_rd <= hit_mem[pg_ra];
	end

	assign res = res_q;

endmodule

// ===== sv/sample_address_histogram.sv =====
// Sampled code address histogram.
// Requests enter as words through push/full; results leave as words through
// empty/pop, one result word for every request word, in request order. A request
// loads a module entry, sets the module count, profiles one sample address, or
// reads back a counter. Three registers, written through wr_en/wr_index/wr_data,
// pick the module for the 1 KB map, the module for the fine window, and the
// window's starting offset. The user must write them only while the block is
// idle; the block itself does not enforce this.
// A front queue of two words classifies requests; the engine behind it runs one
// request at a time through memories that each have a write port and a
// registered read port. A sample scans the module table, makes up to three
// counter updates (module, 1 KB map, fine window), then scans the page table;
// this scan sets the throughput.
// After reset the engine zeroes the module, 1 KB map and fine window counter
// memories; requests wait in the front queue until then. If the receiver stops
// popping, the two-word result queue fills, the engine holds its finished word,
// and full rises at the input.
module sample_address_histogram import sah_pkg::*; #(
	parameter int MODULE_ENTRIES  = DEF_MODULE_ENTRIES,
	parameter int PAGE_ENTRIES    = DEF_PAGE_ENTRIES,
	parameter int FULL_BUCKETS    = DEF_FULL_BUCKETS,
	parameter int FULL_SHIFT_BITS = DEF_FULL_SHIFT_BITS,
	parameter int FINE_SHIFT_BITS = DEF_FINE_SHIFT_BITS,
	parameter int FINE_BUCKETS    = DEF_FINE_BUCKETS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [11:0] slot,
	input  logic [31:0] address,
	input  logic [31:0] span,
	input  logic [2:0]  table_select,
	output logic        empty,
	input  logic        pop,
	output logic        module_hit,
	output logic [8:0]  module_index,
	output logic [31:0] offset,
	output logic [1:0]  page_status,
	output logic [63:0] count_value,
	output logic [8:0]  entry_module,
	output logic [19:0] entry_page,
	output logic        status
);

	cfg_t cfg_q;
	logic rq_valid, rq_pop, res_push, res_full;
	req_t rq;
	res_t res, res_out;

	// Configuration registers; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_map_module    <= MREG_RESET;
			cfg_q.fine_window_module <= MREG_RESET;
			cfg_q.fine_window_base   <= FINE_BASE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_FULL_MAP:  cfg_q.full_map_module    <= wr_data[9:0];
				CFG_FINE_MOD:  cfg_q.fine_window_module <= wr_data[9:0];
				CFG_FINE_BASE: cfg_q.fine_window_base   <= wr_data;
				default: ;
			endcase
		end
	end

	sah_front #(.MODULE_ENTRIES(MODULE_ENTRIES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.slot        (slot),
		.address     (address),
		.span        (span),
		.table_select(table_select),
		.rq_valid    (rq_valid),
		.rq          (rq),
		.rq_pop      (rq_pop)
	);

	sah_engine #(
		.MODULE_ENTRIES (MODULE_ENTRIES),
		.PAGE_ENTRIES   (PAGE_ENTRIES),
		.FULL_BUCKETS   (FULL_BUCKETS),
		.FULL_SHIFT_BITS(FULL_SHIFT_BITS),
		.FINE_SHIFT_BITS(FINE_SHIFT_BITS),
		.FINE_BUCKETS   (FINE_BUCKETS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rq_valid(rq_valid),
		.rq      (rq),
		.rq_pop  (rq_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res     (res)
	);

	// Result queue: decouples the engine from a stalled receiver.
	sah_fifo #(.W($bits(res_t)), .DEPTH(2)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign module_hit   = res_out.module_hit;
	assign module_index = res_out.module_index;
	assign offset       = res_out.offset;
	assign page_status  = res_out.page_status;
	assign count_value  = res_out.count_value;
	assign entry_module = res_out.entry_module;
	assign entry_page   = res_out.entry_page;
	assign status       = res_out.status;

	// The engine never hands a word to a full result queue.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result word pushed into a full queue");

	// The engine only takes a request word that the front queue holds.
	assert property (@(posedge clk) disable iff (!arst_n) rq_pop |-> rq_valid)
		else $error("request word taken from an empty queue");

	// A result word that the engine pushes makes the result queue non-empty at the output.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |=> !empty)
		else $error("pushed result word not visible at the output");

endmodule
